>>> sv/dip_pkg.sv
// ============================================================================
// Dotted IPv4 text parser package
// Shared parser state type, phase and base codes, and the reset state.
// ============================================================================
`default_nettype none

package dip_pkg;

  localparam int unsigned NUM_PARTS = 4;

  // Number base of the part that is being read.
  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  // Where the parser stands within the text.
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TAIL   = 3'd3,
    PH_IGNORE = 3'd4
  } phase_t;

  typedef struct packed {
    logic [NUM_PARTS-1:0][31:0] parts;
    logic [2:0]                 count;
    base_t                      base;
    phase_t                     phase;
    logic                       rejected;
  } state_t;

  localparam state_t STATE_RESET = '{
    parts:    '0,
    count:    3'd0,
    base:     BASE_DEC,
    phase:    PH_START,
    rejected: 1'b0
  };

endpackage

`default_nettype wire

>>> sv/dip_char_if.sv
// ============================================================================
// Character channel
// Valid/ready channel that carries one text byte per beat.
// ============================================================================
`default_nettype none

interface dip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

`default_nettype wire

>>> sv/dip_addr_if.sv
// ============================================================================
// Address channel
// Valid/ready channel that carries one packed 32-bit address per beat.
// ============================================================================
`default_nettype none

interface dip_addr_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

`default_nettype wire

>>> sv/dotted_ipv4_text_parser_unit.sv
// ============================================================================
// Dotted IPv4 text parser unit
// Reads address text one byte per beat and emits one packed 32-bit address
// for every zero byte that ends a string; all ones marks bad text.
// ============================================================================
//
//   Channel   Direction  Payload               Beat meaning
//   in_chan   sink       character [7:0]       one byte of text, zero ends it
//   out_chan  source     address   [31:0]      packed address of one string
//
// One byte is taken every cycle. An accepted byte sits in the input register
// while the parser state is updated; a terminator then loads the result
// register, which drives the address onto out_chan.
// The input stalls only when a terminator waits on a result that is not yet
// taken. Reset (rst_n low, synchronous) clears the parser state and both
// valid flags.
`default_nettype none

module dotted_ipv4_text_parser_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  dip_char_if.sink        in_chan,
  dip_addr_if.source      out_chan
);

  logic            s1_valid_r;
  logic [7:0]      s1_char_r;
  dip_pkg::state_t state_r;
  dip_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic [31:0]     out_addr_r;
  logic [31:0]     step_addr;
  logic            s1_is_term;
  logic            s1_go;

  dip_step u_step (
    .cur_state (state_r),
    .character (s1_char_r),
    .nxt_state (state_nxt),
    .address   (step_addr)
  );

  // A terminator moves on only when the result register is free.
  assign s1_is_term    = (s1_char_r == 8'h00);
  assign s1_go         = s1_valid_r && (!s1_is_term || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      s1_char_r <= in_chan.character;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dip_pkg::STATE_RESET;
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_is_term) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_go && s1_is_term) begin
      out_addr_r <= step_addr;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.address = out_addr_r;

endmodule

`default_nettype wire

>>> sv/dip_step.sv
// ============================================================================
// Parser step
// Next parser state for one text byte, and the packed address that a
// terminating zero byte produces.
// ============================================================================
`default_nettype none

module dip_step (
  input  wire  dip_pkg::state_t cur_state,
  input  wire  logic [7:0]      character,
  output dip_pkg::state_t       nxt_state,
  output logic [31:0]           address
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Range check against the classic layouts and pack, first part on top.
  function automatic logic [31:0] pack_address(input dip_pkg::state_t st,
                                               input logic [2:0] cnt);
    logic [31:0] a, b, c, d;
    logic [31:0] res;
    a = st.parts[0];
    b = st.parts[1];
    c = st.parts[2];
    d = st.parts[3];
    res = ALL_ONES;
    case (cnt)
      3'd1: res = a;
      3'd2: if (a <= 32'hFF && b <= 32'hFF_FFFF) begin
        res = {a[7:0], b[23:0]};
      end
      3'd3: if (a <= 32'hFF && b <= 32'hFF && c <= 32'hFFFF) begin
        res = {a[7:0], b[7:0], c[15:0]};
      end
      3'd4: if (a <= 32'hFF && b <= 32'hFF && c <= 32'hFF && d <= 32'hFF) begin
        res = {a[7:0], b[7:0], c[7:0], d[7:0]};
      end
      default: res = ALL_ONES;
    endcase
    if (st.rejected) begin
      res = ALL_ONES;
    end
    return res;
  endfunction

  logic        is_space;
  logic        do_digit;
  logic        is_num;
  logic [3:0]  digit_val;
  logic [1:0]  idx;
  logic [31:0] part_cur;
  logic [31:0] part_scaled;
  logic [2:0]  term_count;
  logic [2:0]  next_count;

  assign is_space = (character == CH_SPACE) || (character == CH_TAB) ||
                    (character == CH_NL) || (character == CH_CR);
  assign idx      = cur_state.count[1:0];
  assign part_cur = cur_state.parts[idx];

  // A terminator closes the open part unless the text has already ended.
  always_comb begin
    term_count = cur_state.count;
    if (cur_state.phase == dip_pkg::PH_START || cur_state.phase == dip_pkg::PH_ZERO ||
        cur_state.phase == dip_pkg::PH_DIGITS) begin
      term_count = cur_state.count + 3'd1;
    end
    address = pack_address(cur_state, term_count);
  end

  // Per-byte state update.
  always_comb begin
    nxt_state   = cur_state;
    do_digit    = 1'b0;
    is_num      = 1'b0;
    digit_val   = 4'd0;
    part_scaled = '0;
    next_count  = cur_state.count + 3'd1;

    if (character == CH_NUL) begin
      nxt_state = dip_pkg::STATE_RESET;
    end else begin
      case (cur_state.phase)
        dip_pkg::PH_START: begin
          if (character == CH_ZERO) begin
            nxt_state.phase = dip_pkg::PH_ZERO;
          end else begin
            nxt_state.base = dip_pkg::BASE_DEC;
            do_digit       = 1'b1;
          end
        end
        dip_pkg::PH_ZERO: begin
          if (character == CH_LX || character == CH_UX) begin
            nxt_state.base  = dip_pkg::BASE_HEX;
            nxt_state.phase = dip_pkg::PH_DIGITS;
          end else begin
            nxt_state.base = dip_pkg::BASE_OCT;
            do_digit       = 1'b1;
          end
        end
        dip_pkg::PH_DIGITS: do_digit = 1'b1;
        dip_pkg::PH_TAIL: begin
          if (!is_space) begin
            nxt_state.rejected = 1'b1;
          end
          nxt_state.phase = dip_pkg::PH_IGNORE;
        end
        default: ;
      endcase

      // Digit decode uses the base chosen above.
      if (character >= CH_ZERO && character <= CH_NINE) begin
        is_num    = 1'b1;
        digit_val = 4'(character - CH_ZERO);
      end else if (nxt_state.base == dip_pkg::BASE_HEX && character >= CH_LA &&
                   character <= CH_LF) begin
        is_num    = 1'b1;
        digit_val = 4'(character - CH_LA + 8'd10);
      end else if (nxt_state.base == dip_pkg::BASE_HEX && character >= CH_UA &&
                   character <= CH_UF) begin
        is_num    = 1'b1;
        digit_val = 4'(character - CH_UA + 8'd10);
      end

      // Multiply by the base with shifts, then add the digit.
      case (nxt_state.base)
        dip_pkg::BASE_HEX: part_scaled = {part_cur[27:0], 4'd0};
        dip_pkg::BASE_OCT: part_scaled = {part_cur[28:0], 3'd0};
        default:           part_scaled = {part_cur[28:0], 3'd0} + {part_cur[30:0], 1'b0};
      endcase

      if (do_digit) begin
        if (is_num) begin
          nxt_state.parts[idx] = part_scaled + {28'd0, digit_val};
          nxt_state.phase      = dip_pkg::PH_DIGITS;
        end else begin
          nxt_state.count = next_count;
          if (character == CH_DOT) begin
            if (next_count < 3'd4) begin
              nxt_state.parts[next_count[1:0]] = '0;
              nxt_state.base  = dip_pkg::BASE_DEC;
              nxt_state.phase = dip_pkg::PH_START;
            end else begin
              nxt_state.phase = dip_pkg::PH_TAIL;
            end
          end else begin
            if (!is_space) begin
              nxt_state.rejected = 1'b1;
            end
            nxt_state.phase = dip_pkg::PH_IGNORE;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> verif/ipv4_addr_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Address checker for the dotted IPv4 text parser
// Watches the character and address channels, runs its own parser on every
// accepted text byte, and compares each address beat with the oldest
// predicted address. Counts failures for the testbench top.
// ============================================================================

module ipv4_addr_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              char_valid,
  input  logic              char_ready,
  input  logic [7:0]        char_byte,
  input  logic              addr_valid,
  input  logic              addr_ready,
  input  logic [31:0]       addr_value,
  output int unsigned       fail_count,
  output int unsigned       pending_count,
  output int unsigned       checked_count
);

  // Text bytes with a meaning to the parser.
  localparam logic [7:0] CHR_NUL     = 8'h00;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_LF      = 8'h0A;
  localparam logic [7:0] CHR_CR      = 8'h0D;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_DOT     = 8'h2E;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_F = 8'h46;
  localparam logic [7:0] CHR_UPPER_X = 8'h58;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_F = 8'h66;
  localparam logic [7:0] CHR_LOWER_X = 8'h78;

  localparam logic [31:0] ADDR_INVALID = 32'hFFFF_FFFF;
  localparam int unsigned MAX_REPORTS  = 10;

  // Shadow copy of the parser state.
  logic [31:0]      part_vals [dip_pkg::NUM_PARTS];
  logic [2:0]       parts_done;
  dip_pkg::base_t   num_base;
  dip_pkg::phase_t  phase;
  logic             text_bad;

  // Addresses predicted but not yet seen on the output.
  logic [31:0] expected_addrs [$];
  int unsigned reported;

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == CHR_SPACE || ch == CHR_TAB || ch == CHR_LF || ch == CHR_CR;
  endfunction

  task automatic clear_parser();
    for (int i = 0; i < dip_pkg::NUM_PARTS; i++) begin
      part_vals[i] = '0;
    end
    parts_done = '0;
    num_base   = dip_pkg::BASE_DEC;
    phase      = dip_pkg::PH_START;
    text_bad   = 1'b0;
  endtask

  // Range check of the finished parts against the a / a.b / a.b.c / a.b.c.d
  // layouts, then packing with the first part on top.
  function automatic logic [31:0] packed_address();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    a = part_vals[0];
    b = part_vals[1];
    c = part_vals[2];
    d = part_vals[3];
    if (text_bad) begin
      return ADDR_INVALID;
    end
    case (parts_done)
      3'd1: return a;
      3'd2: begin
        if (a > 32'hFF || b > 32'hFF_FFFF) return ADDR_INVALID;
        return (a << 24) | b;
      end
      3'd3: begin
        if (a > 32'hFF || b > 32'hFF || c > 32'hFFFF) return ADDR_INVALID;
        return (a << 24) | (b << 16) | c;
      end
      3'd4: begin
        if (a > 32'hFF || b > 32'hFF || c > 32'hFF || d > 32'hFF) return ADDR_INVALID;
        return (a << 24) | (b << 16) | (c << 8) | d;
      end
      default: return ADDR_INVALID;
    endcase
  endfunction

  // One byte inside the digits of a part: either a digit of the current base,
  // or the byte that closes the part.
  task automatic take_part_byte(input logic [7:0] ch);
    logic [31:0] weight;
    logic [31:0] digit;
    logic        digit_ok;
    logic [1:0]  slot;
    slot     = parts_done[1:0];
    weight   = (num_base == dip_pkg::BASE_HEX) ? 32'd16 :
               ((num_base == dip_pkg::BASE_OCT) ? 32'd8 : 32'd10);
    digit_ok = 1'b1;
    digit    = '0;
    if (ch >= CHR_ZERO && ch <= CHR_NINE) begin
      digit = 32'(ch - CHR_ZERO);
    end else if (num_base == dip_pkg::BASE_HEX && ch >= CHR_LOWER_A &&
                 ch <= CHR_LOWER_F) begin
      digit = 32'(ch - CHR_LOWER_A) + 32'd10;
    end else if (num_base == dip_pkg::BASE_HEX && ch >= CHR_UPPER_A &&
                 ch <= CHR_UPPER_F) begin
      digit = 32'(ch - CHR_UPPER_A) + 32'd10;
    end else begin
      digit_ok = 1'b0;
    end

    if (digit_ok) begin
      part_vals[slot] = part_vals[slot] * weight + digit;
      phase = dip_pkg::PH_DIGITS;
    end else begin
      parts_done = parts_done + 3'd1;
      if (ch == CHR_DOT) begin
        if (parts_done < 3'd4) begin
          part_vals[parts_done[1:0]] = '0;
          num_base = dip_pkg::BASE_DEC;
          phase    = dip_pkg::PH_START;
        end else begin
          phase = dip_pkg::PH_TAIL;
        end
      end else begin
        if (!is_blank(ch)) text_bad = 1'b1;
        phase = dip_pkg::PH_IGNORE;
      end
    end
  endtask

  // Advance the shadow parser by one accepted text byte.
  task automatic parse_text_byte(input logic [7:0] ch);
    if (ch == CHR_NUL) begin
      if (phase inside {dip_pkg::PH_START, dip_pkg::PH_ZERO, dip_pkg::PH_DIGITS}) begin
        parts_done = parts_done + 3'd1;
      end
      expected_addrs.push_back(packed_address());
      clear_parser();
    end else begin
      case (phase)
        dip_pkg::PH_START: begin
          if (ch == CHR_ZERO) begin
            phase = dip_pkg::PH_ZERO;
          end else begin
            num_base = dip_pkg::BASE_DEC;
            take_part_byte(ch);
          end
        end
        dip_pkg::PH_ZERO: begin
          if (ch == CHR_LOWER_X || ch == CHR_UPPER_X) begin
            num_base = dip_pkg::BASE_HEX;
            phase    = dip_pkg::PH_DIGITS;
          end else begin
            num_base = dip_pkg::BASE_OCT;
            take_part_byte(ch);
          end
        end
        dip_pkg::PH_DIGITS: take_part_byte(ch);
        dip_pkg::PH_TAIL: begin
          if (!is_blank(ch)) text_bad = 1'b1;
          phase = dip_pkg::PH_IGNORE;
        end
        default: ;
      endcase
    end
  endtask

  // Compare before predicting: an address leaving now always belongs to an
  // older string than a terminator arriving in the same cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_addrs.delete();
      fail_count    = 0;
      checked_count = 0;
      reported      = 0;
    end else begin
      if (addr_valid && addr_ready) begin
        if (expected_addrs.size() == 0) begin
          fail_count++;
          if (reported < MAX_REPORTS) begin
            reported++;
            $display("ERROR: unexpected address beat %08h with no string pending", addr_value);
          end
        end else begin
          logic [31:0] want;
          want = expected_addrs.pop_front();
          checked_count++;
          if (addr_value !== want) begin
            fail_count++;
            if (reported < MAX_REPORTS) begin
              reported++;
              $display("ERROR: address beat %0d: expected %08h, got %08h",
                       checked_count, want, addr_value);
            end
          end
        end
      end
      if (char_valid && char_ready) begin
        parse_text_byte(char_byte);
      end
    end
    pending_count = expected_addrs.size();
  end

endmodule

>>> verif/tb_dotted_ipv4_text_parser_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the dotted IPv4 text parser unit
// Feeds address strings byte by byte (directed corner cases, then random
// well-formed, broken and noise strings) with bursty input and a stalling
// output side; a separate checker predicts and compares every address.
// ============================================================================

module tb_dotted_ipv4_text_parser_unit;

  localparam int unsigned TEXT_BYTES  = 1950;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_WAIT  = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dip_char_if char_chan ();
  dip_addr_if addr_chan ();

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned checked_count;

  // Stimulus bookkeeping.
  logic [7:0]  text_bytes [$];
  int unsigned bytes_sent;
  int unsigned strings_sent;
  int unsigned burst_left;
  int unsigned cycle_count;

  // Output-side stall control.
  bit          hold_request;
  int unsigned hold_left;
  int unsigned holds_done;
  int unsigned stall_mode;
  int unsigned mode_left;

  dotted_ipv4_text_parser_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (char_chan),
    .out_chan (addr_chan)
  );

  ipv4_addr_checker addr_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .char_valid    (char_chan.valid),
    .char_ready    (char_chan.ready),
    .char_byte     (char_chan.character),
    .addr_valid    (addr_chan.valid),
    .addr_ready    (addr_chan.ready),
    .addr_value    (addr_chan.address),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d addresses pending", cycle_count, pending_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Output side: a long hold on request, otherwise a stall pattern that
  // switches between always ready, coin toss and mostly stalled.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      addr_chan.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        0:       addr_chan.ready <= 1'b1;
        1:       addr_chan.ready <= 1'($urandom_range(0, 1));
        default: addr_chan.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Drive one byte, starting and ending at a falling edge. Bursts of random
  // length are separated by random gaps; some bursts are long and gapless.
  task automatic send_byte(input logic [7:0] ch);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(100, 300);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap > 0) begin
        char_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    char_chan.valid     <= 1'b1;
    char_chan.character <= ch;
    do @(posedge clk); while (!char_chan.ready);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_bytes[i]) begin
      send_byte(text_bytes[i]);
    end
    strings_sent++;
  endtask

  // Stop offering bytes until every predicted address has come out.
  task automatic wait_drained();
    char_chan.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_bytes.push_back(s[i]);
    end
  endtask

  // Append v in the given radix, most significant digit first; hex letters
  // take a random case per digit.
  task automatic push_digits(input logic [31:0] v, input int unsigned radix);
    logic [7:0]  digs [$];
    logic [31:0] d;
    do begin
      d = v % radix;
      if (d < 10) digs.push_front(8'("0") + 8'(d));
      else if ($urandom_range(0, 1)) digs.push_front(8'("A") + 8'(d - 10));
      else digs.push_front(8'("a") + 8'(d - 10));
      v = v / radix;
    end while (v != 0);
    foreach (digs[i]) text_bytes.push_back(digs[i]);
  endtask

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0:       return " ";
      1:       return "\t";
      2:       return "\n";
      default: return "\r";
    endcase
  endfunction

  // One part: a value biased toward the layout limits, written in decimal,
  // octal, hex, or as a raw digit run that may overflow or hold 8 and 9
  // after a leading zero.
  task automatic add_part();
    logic [31:0] v;
    int unsigned fmt;
    case ($urandom_range(0, 15))
      0:       v = 32'd0;
      1:       v = 32'hFF;
      2:       v = 32'h100;
      3:       v = 32'hFFFF;
      4:       v = 32'h1_0000;
      5:       v = 32'hFF_FFFF;
      6:       v = 32'h100_0000;
      7:       v = 32'hFFFF_FFFF;
      8:       v = $urandom;
      default: v = $urandom_range(0, 255);
    endcase
    fmt = $urandom_range(0, 9);
    if (fmt < 5) begin
      push_digits(v, 10);
    end else if (fmt < 7) begin
      push_text("0");
      push_digits(v, 8);
    end else if (fmt < 9) begin
      push_text($urandom_range(0, 1) ? "0x" : "0X");
      if (v != 0 || $urandom_range(0, 1)) push_digits(v, 16);
    end else begin
      repeat ($urandom_range(1, 14)) text_bytes.push_back(8'("0") + 8'($urandom_range(0, 9)));
    end
  endtask

  // Build one random string, terminator included.
  task automatic build_string();
    int unsigned kind;
    int unsigned nparts;
    int unsigned pos;
    text_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      nparts = $urandom_range(1, 4);
      for (int p = 0; p < nparts; p++) begin
        if (p > 0) push_text(".");
        if ($urandom_range(0, 19) != 0) add_part();
      end
      // Tail: nothing, whitespace with junk behind it, or a trailing dot.
      case ($urandom_range(0, 9))
        0, 1: begin
          text_bytes.push_back(blank_byte());
          repeat ($urandom_range(0, 5)) text_bytes.push_back(8'($urandom_range(1, 255)));
        end
        2: begin
          push_text(".");
          if ($urandom_range(0, 1)) text_bytes.push_back(blank_byte());
          if ($urandom_range(0, 1)) text_bytes.push_back(8'($urandom_range(1, 255)));
        end
        default: ;
      endcase
      // Broken strings: one byte overwritten with a random nonzero byte.
      if (kind >= 70 && text_bytes.size() > 0) begin
        pos = $urandom_range(0, text_bytes.size() - 1);
        text_bytes[pos] = 8'($urandom_range(1, 255));
      end
    end else begin
      repeat ($urandom_range(1, 10)) text_bytes.push_back(8'($urandom_range(1, 255)));
    end
    text_bytes.push_back(8'h00);
  endtask

  initial begin
    char_chan.valid     = 1'b0;
    char_chan.character = 8'h00;
    addr_chan.ready     = 1'b0;
    hold_request        = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed strings: empty text, hex with upper-case prefix and letter,
    // octal holding a 9, an empty middle part, a trailing dot after the
    // fourth part, and a lone bad byte with every bit set.
    text_bytes = {8'h00};
    send_text();
    text_bytes.delete(); push_text("0XF"); text_bytes.push_back(8'h00);
    send_text();
    text_bytes.delete(); push_text("09"); text_bytes.push_back(8'h00);
    send_text();
    text_bytes.delete(); push_text("1..2"); text_bytes.push_back(8'h00);
    send_text();
    text_bytes.delete(); push_text("0.0.0.0."); text_bytes.push_back(8'h00);
    send_text();
    text_bytes = {8'hFF, 8'h00};
    send_text();
    wait_drained();

    // Random strings, with two long output holds while input keeps coming,
    // each followed by a full drain.
    while (bytes_sent < TEXT_BYTES) begin
      if ((holds_done == 0 && bytes_sent > TEXT_BYTES / 3) ||
          (holds_done == 1 && bytes_sent > 2 * TEXT_BYTES / 3)) begin
        hold_request = 1'b1;
        repeat (12) begin
          build_string();
          send_text();
        end
        wait_drained();
      end else begin
        build_string();
        send_text();
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end

    char_chan.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Summary: %0d text bytes in %0d strings, %0d addresses checked, %0d long output holds",
             bytes_sent, strings_sent, checked_count, holds_done);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
